FILE: rtl/core/imugc_pkg.sv
// Shared constants and types for the IMU gravity compensation core.
`default_nettype none
package imugc_pkg;

  // Number of calibration items averaged into one bias set.
  localparam int unsigned CAL_SAMPLES = 100;
  localparam logic [9:0]  CAL_DIVISOR = 10'(CAL_SAMPLES);
  localparam logic [9:0]  CAL_ROUND   = 10'(CAL_SAMPLES - 1);

  // Angle step of 1/16 degree in Q62 radians, and one in Q62.
  localparam logic [63:0] PI_Q62   = 64'hC90F_DAA2_2168_C235;
  localparam logic [63:0] STEP_Q62 = PI_Q62 / 64'd2880;
  localparam logic [63:0] Q62_ONE  = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HALF_Q15 = 64'h0000_4000_0000_0000;

  localparam logic [13:0] FULL_TURN    = 14'd5760;
  localparam logic [12:0] QUARTER_TURN = 13'd1440;
  localparam logic [12:0] HALF_TURN    = 13'd2880;
  localparam logic [12:0] THREE_QUART  = 13'd4320;

  localparam logic [3:0] SERIES_TERMS = 4'd13;
  localparam logic [5:0] SERIAL_LAST  = 6'd63;
  localparam logic [5:0] ROOT_LAST    = 6'd27;
  localparam logic [2:0] LAST_CH      = 3'd5;

  // Sample channels.
  localparam logic [2:0] CH_AX = 3'd0;
  localparam logic [2:0] CH_AY = 3'd1;
  localparam logic [2:0] CH_AZ = 3'd2;
  localparam logic [2:0] CH_GX = 3'd3;
  localparam logic [2:0] CH_GY = 3'd4;
  localparam logic [2:0] CH_GZ = 3'd5;

  // Product steps of the shared small multiplier.
  localparam logic [2:0] PR_GX_COS = 3'd0;
  localparam logic [2:0] PR_GY_SIN = 3'd1;
  localparam logic [2:0] PR_GX_SIN = 3'd2;
  localparam logic [2:0] PR_GY_COS = 3'd3;
  localparam logic [2:0] PR_SQ_X   = 3'd4;
  localparam logic [2:0] PR_SQ_Y   = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAL_LOAD,
    ST_CAL_DIV,
    ST_CAL_STORE,
    ST_MUL_X,
    ST_MUL_X2,
    ST_TS_MUL,
    ST_TS_DIV,
    ST_TC_MUL,
    ST_TC_DIV,
    ST_ROUND,
    ST_PROD,
    ST_LIN,
    ST_SQ,
    ST_SQRT,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

FILE: rtl/core/imu_gravity_compensation_core.sv
// Top level of the IMU gravity and gyro bias compensation core.
`default_nettype none
// A calibration item (func 0) is added to six bias accumulators and is taken
// without making the block busy; the item that completes a calibration set is
// followed by a phase in which six averages are formed by a bit-serial divider
// (six passes of 64 steps). A measurement item (func 1) gives one result.
// With the link flag low that result is all zero and passes through the done
// state into the output register. With the link up the sine and cosine of the
// steering angle are evaluated by a 13-term series on a bit-serial 64-bit
// multiplier and a bit-serial divider, in 54 operations, followed by a few
// product steps and a 28-step square root. One item is worked on at a time.
// A finished result sits in an output register, so the next item is taken
// while the result still waits to be collected.
module imu_gravity_compensation_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               func_i,
  input  wire logic               link_ok_i,
  input  wire logic signed [15:0] raw_accel_x_i,
  input  wire logic signed [15:0] raw_accel_y_i,
  input  wire logic signed [15:0] raw_accel_z_i,
  input  wire logic signed [15:0] raw_gyro_x_i,
  input  wire logic signed [15:0] raw_gyro_y_i,
  input  wire logic signed [15:0] raw_gyro_z_i,
  input  wire logic signed [12:0] steer_angle_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [25:0]      lin_accel_x_o,
  output logic signed [25:0]      lin_accel_y_o,
  output logic signed [25:0]      lin_accel_z_o,
  output logic signed [25:0]      rate_x_o,
  output logic signed [25:0]      rate_y_o,
  output logic signed [25:0]      rate_z_o,
  output logic        [24:0]      g_force_o
);
  import imugc_pkg::*;

  state_e state_q, state_d;
  logic [5:0] cnt_q;
  logic [3:0] k_q;
  logic [2:0] ch_q;
  logic [2:0] idx_q;
  logic       out_valid_q;
  logic [7:0] count_q;
  logic signed [24:0] sums_q [6];
  logic signed [23:0] avg_q  [6];

  // Item payload and datapath registers.
  logic signed [15:0] raw_q [6];
  logic               link_q;
  logic [1:0]         quad_q;
  logic [63:0]        ma_q;
  logic [127:0]       prod_q;
  logic [9:0]         dvs_q;
  logic [9:0]         rem_q;
  logic [63:0]        quo_q;
  logic               neg_q;
  logic [63:0]        x2_q, ts_q, tc_q;
  logic signed [63:0] ss_q, cs_q;
  logic signed [17:0] sn_q, co_q;
  logic signed [41:0] ex_q, ey_q;
  logic signed [26:0] linx_q, liny_q;
  logic [55:0]        sq_q;
  logic [55:0]        rt_v_q, rt_res_q, rt_bit_q;

  logic signed [25:0] lax_q, lay_q, laz_q, rx_q, ry_q, rz_q;
  logic [24:0]        gf_q;

  logic in_acc, out_load, last, cal_full;
  logic signed [13:0] ang;
  logic signed [13:0] ang_w;
  logic [12:0]        ang_a;
  logic [1:0]         quad_a;
  logic [10:0]        rem_a;

  logic [64:0]        mul_sum;
  logic [127:0]       mul_next;
  logic [10:0]        div_t;
  logic               div_ge;
  logic [9:0]         div_rem_next;
  logic [63:0]        div_quo_next;

  logic [63:0]        ss_pos, cs_pos, ss_rnd, cs_rnd;
  logic [16:0]        s0, c0;

  logic signed [26:0] mop_a, mop_b;
  logic signed [53:0] mprod;
  logic signed [41:0] num_x, num_y;
  logic [55:0]        rt_t;

  logic signed [32:0] cal_n;
  logic [32:0]        cal_mag;
  logic [33:0]        cal_div;

  function automatic logic [9:0] sin_div(input logic [3:0] k);
    logic [9:0] kk;
    kk = {6'b0, k};
    return 10'(4 * kk * kk + 2 * kk);
  endfunction

  function automatic logic [9:0] cos_div(input logic [3:0] k);
    logic [9:0] kk;
    kk = {6'b0, k};
    return 10'(4 * kk * kk - 2 * kk);
  endfunction

  function automatic logic signed [15:0] raw_in(input int i);
    logic signed [15:0] v;
    case (i)
      0:       v = raw_accel_x_i;
      1:       v = raw_accel_y_i;
      2:       v = raw_accel_z_i;
      3:       v = raw_gyro_x_i;
      4:       v = raw_gyro_y_i;
      default: v = raw_gyro_z_i;
    endcase
    return v;
  endfunction

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_load   = (state_q == ST_DONE) & (~out_valid_q | ~out_stall_i);
  assign last       = (cnt_q == SERIAL_LAST);
  assign cal_full   = ({1'b0, count_q} + 9'd1) >= 9'(CAL_SAMPLES);

  // Steering angle negated and folded into one turn, then split in quadrants.
  always_comb begin
    ang   = -{steer_angle_i[12], steer_angle_i};
    ang_w = ang[13] ? ang + $signed(FULL_TURN) : ang;
    ang_a = ang_w[12:0];
    if (ang_a < QUARTER_TURN) begin
      quad_a = 2'd0;
      rem_a  = ang_a[10:0];
    end else if (ang_a < HALF_TURN) begin
      quad_a = 2'd1;
      rem_a  = 11'(ang_a - QUARTER_TURN);
    end else if (ang_a < THREE_QUART) begin
      quad_a = 2'd2;
      rem_a  = 11'(ang_a - HALF_TURN);
    end else begin
      quad_a = 2'd3;
      rem_a  = 11'(ang_a - THREE_QUART);
    end
  end

  // Bit-serial multiplier: one multiplier bit per cycle, low half shifts out.
  assign mul_sum  = {1'b0, prod_q[127:64]} + (prod_q[0] ? {1'b0, ma_q} : 65'd0);
  assign mul_next = {mul_sum, prod_q[63:1]};

  // Bit-serial restoring divider by a narrow constant divisor.
  assign div_t        = {rem_q, quo_q[63]};
  assign div_ge       = div_t >= {1'b0, dvs_q};
  assign div_rem_next = div_ge ? 10'(div_t - {1'b0, dvs_q}) : div_t[9:0];
  assign div_quo_next = {quo_q[62:0], div_ge};

  // Rounding of the series sums to Q15 magnitudes; negative sums clamp to zero.
  always_comb begin
    ss_pos = ss_q[63] ? 64'd0 : ss_q;
    cs_pos = cs_q[63] ? 64'd0 : cs_q;
    ss_rnd = ss_pos + HALF_Q15;
    cs_rnd = cs_pos + HALF_Q15;
    s0     = ss_rnd[63:47];
    c0     = cs_rnd[63:47];
  end

  // Shared small signed multiplier for the rotation and the squares.
  always_comb begin
    mop_a = '0;
    mop_b = '0;
    case (idx_q)
      PR_GX_COS: begin
        mop_a = 27'(avg_q[CH_AX]);
        mop_b = 27'(co_q);
      end
      PR_GY_SIN: begin
        mop_a = 27'(avg_q[CH_AY]);
        mop_b = 27'(sn_q);
      end
      PR_GX_SIN: begin
        mop_a = 27'(avg_q[CH_AX]);
        mop_b = 27'(sn_q);
      end
      PR_GY_COS: begin
        mop_a = 27'(avg_q[CH_AY]);
        mop_b = 27'(co_q);
      end
      PR_SQ_X: begin
        mop_a = linx_q;
        mop_b = linx_q;
      end
      PR_SQ_Y: begin
        mop_a = liny_q;
        mop_b = liny_q;
      end
      default: begin
        mop_a = '0;
        mop_b = '0;
      end
    endcase
  end
  assign mprod = mop_a * mop_b;

  assign num_x = $signed({{3{raw_q[CH_AX][15]}}, raw_q[CH_AX], 23'b0}) - ex_q
               + 42'sd16384;
  assign num_y = $signed({{3{raw_q[CH_AY][15]}}, raw_q[CH_AY], 23'b0}) - ey_q
               + 42'sd16384;
  assign rt_t  = rt_res_q + rt_bit_q;

  // Bias average: floor(sum * 256 / N) through a magnitude division.
  always_comb begin
    cal_n   = {sums_q[ch_q], 8'b0};
    cal_mag = cal_n[32] ? 33'(-cal_n) : 33'(cal_n);
    cal_div = {1'b0, cal_mag} + (cal_n[32] ? {24'b0, CAL_ROUND} : 34'd0);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!func_i) begin
            state_d = cal_full ? ST_CAL_LOAD : ST_IDLE;
          end else if (!link_ok_i) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_MUL_X;
          end
        end
      end
      ST_CAL_LOAD:  state_d = ST_CAL_DIV;
      ST_CAL_DIV:   if (last) state_d = ST_CAL_STORE;
      ST_CAL_STORE: state_d = (ch_q == LAST_CH) ? ST_IDLE : ST_CAL_LOAD;
      ST_MUL_X:     if (last) state_d = ST_MUL_X2;
      ST_MUL_X2:    if (last) state_d = ST_TS_MUL;
      ST_TS_MUL:    if (last) state_d = ST_TS_DIV;
      ST_TS_DIV:    if (last) state_d = ST_TC_MUL;
      ST_TC_MUL:    if (last) state_d = ST_TC_DIV;
      ST_TC_DIV: begin
        if (last) state_d = (k_q == SERIES_TERMS) ? ST_ROUND : ST_TS_MUL;
      end
      ST_ROUND:     state_d = ST_PROD;
      ST_PROD:      if (idx_q == PR_GY_COS) state_d = ST_LIN;
      ST_LIN:       state_d = ST_SQ;
      ST_SQ:        if (idx_q == PR_SQ_Y) state_d = ST_SQRT;
      ST_SQRT:      if (cnt_q == ROOT_LAST) state_d = ST_DONE;
      ST_DONE:      if (out_load) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Control state, calibration accumulators and bias averages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      ch_q        <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      for (int i = 0; i < 6; i++) begin
        sums_q[i] <= '0;
        avg_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_d != state_q) ? 6'd0 : 6'(cnt_q + 6'd1);

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (in_acc && !func_i) begin
        for (int i = 0; i < 6; i++) begin
          sums_q[i] <= sums_q[i] + 25'(raw_in(i));
        end
        count_q <= 8'(count_q + 8'd1);
        ch_q    <= CH_AX;
      end

      if (state_q == ST_CAL_STORE) begin
        avg_q[ch_q]  <= neg_q ? 24'(-quo_q[23:0]) : quo_q[23:0];
        sums_q[ch_q] <= '0;
        ch_q         <= 3'(ch_q + 3'd1);
        if (ch_q == LAST_CH) count_q <= '0;
      end

      if (state_q == ST_MUL_X2) k_q <= 4'd1;
      if (state_q == ST_TC_DIV && last) k_q <= 4'(k_q + 4'd1);

      if (state_q == ST_ROUND) idx_q <= PR_GX_COS;
      if (state_q == ST_PROD || state_q == ST_SQ) idx_q <= 3'(idx_q + 3'd1);
    end
  end

  // Serial datapath.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < 6; i++) raw_q[i] <= raw_in(i);
      link_q <= link_ok_i;
      quad_q <= quad_a;
      ma_q   <= STEP_Q62;
      prod_q <= {117'b0, rem_a};
    end

    unique case (state_q)
      ST_CAL_LOAD: begin
        quo_q <= 64'(cal_div);
        rem_q <= '0;
        dvs_q <= CAL_DIVISOR;
        neg_q <= cal_n[32];
      end
      ST_CAL_DIV, ST_TS_DIV, ST_TC_DIV: begin
        rem_q <= div_rem_next;
        quo_q <= div_quo_next;
        if (last && state_q == ST_TS_DIV) begin
          ts_q   <= div_quo_next;
          ss_q   <= k_q[0] ? ss_q - $signed(div_quo_next) : ss_q + $signed(div_quo_next);
          ma_q   <= x2_q;
          prod_q <= {64'b0, tc_q};
        end
        if (last && state_q == ST_TC_DIV) begin
          tc_q   <= div_quo_next;
          cs_q   <= k_q[0] ? cs_q - $signed(div_quo_next) : cs_q + $signed(div_quo_next);
          ma_q   <= x2_q;
          prod_q <= {64'b0, ts_q};
        end
      end
      ST_MUL_X: begin
        if (last) begin
          ts_q   <= mul_next[63:0];
          ss_q   <= $signed(mul_next[63:0]);
          ma_q   <= mul_next[63:0];
          prod_q <= {64'b0, mul_next[63:0]};
        end else begin
          prod_q <= mul_next;
        end
      end
      ST_MUL_X2: begin
        if (last) begin
          x2_q   <= mul_next[125:62];
          tc_q   <= Q62_ONE;
          cs_q   <= $signed(Q62_ONE);
          ma_q   <= mul_next[125:62];
          prod_q <= {64'b0, ts_q};
        end else begin
          prod_q <= mul_next;
        end
      end
      ST_TS_MUL, ST_TC_MUL: begin
        prod_q <= mul_next;
        if (last) begin
          quo_q <= mul_next[125:62];
          rem_q <= '0;
          dvs_q <= (state_q == ST_TS_MUL) ? sin_div(k_q) : cos_div(k_q);
        end
      end
      ST_ROUND: begin
        // Quadrant mapping of the first-quadrant sine and cosine.
        unique case (quad_q)
          2'd0: begin
            sn_q <= $signed({1'b0, s0});
            co_q <= $signed({1'b0, c0});
          end
          2'd1: begin
            sn_q <= $signed({1'b0, c0});
            co_q <= -$signed({1'b0, s0});
          end
          2'd2: begin
            sn_q <= -$signed({1'b0, s0});
            co_q <= -$signed({1'b0, c0});
          end
          default: begin
            sn_q <= -$signed({1'b0, c0});
            co_q <= $signed({1'b0, s0});
          end
        endcase
      end
      ST_PROD: begin
        case (idx_q)
          PR_GX_COS: ex_q <= mprod[41:0];
          PR_GY_SIN: ex_q <= ex_q - mprod[41:0];
          PR_GX_SIN: ey_q <= mprod[41:0];
          default:   ey_q <= ey_q + mprod[41:0];
        endcase
      end
      ST_LIN: begin
        linx_q <= num_x[41:15];
        liny_q <= num_y[41:15];
      end
      ST_SQ: begin
        if (idx_q == PR_SQ_X) begin
          sq_q <= 56'(unsigned'(mprod));
        end else begin
          rt_v_q   <= sq_q + 56'(unsigned'(mprod));
          rt_res_q <= '0;
          rt_bit_q <= 56'd1 << 54;
        end
      end
      ST_SQRT: begin
        if (rt_v_q >= rt_t) begin
          rt_v_q   <= rt_v_q - rt_t;
          rt_res_q <= (rt_res_q >> 1) + rt_bit_q;
        end else begin
          rt_res_q <= rt_res_q >> 1;
        end
        rt_bit_q <= rt_bit_q >> 2;
      end
      default: begin
      end
    endcase

    if (out_load) begin
      if (link_q) begin
        lax_q <= linx_q[25:0];
        lay_q <= liny_q[25:0];
        laz_q <= $signed({{2{raw_q[CH_AZ][15]}}, raw_q[CH_AZ], 8'b0})
               - $signed({{2{avg_q[CH_AZ][23]}}, avg_q[CH_AZ]});
        rx_q  <= $signed({{2{raw_q[CH_GX][15]}}, raw_q[CH_GX], 8'b0})
               - $signed({{2{avg_q[CH_GX][23]}}, avg_q[CH_GX]});
        ry_q  <= $signed({{2{raw_q[CH_GY][15]}}, raw_q[CH_GY], 8'b0})
               - $signed({{2{avg_q[CH_GY][23]}}, avg_q[CH_GY]});
        rz_q  <= $signed({{2{raw_q[CH_GZ][15]}}, raw_q[CH_GZ], 8'b0})
               - $signed({{2{avg_q[CH_GZ][23]}}, avg_q[CH_GZ]});
        gf_q  <= rt_res_q[24:0];
      end else begin
        lax_q <= '0;
        lay_q <= '0;
        laz_q <= '0;
        rx_q  <= '0;
        ry_q  <= '0;
        rz_q  <= '0;
        gf_q  <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign lin_accel_x_o = lax_q;
  assign lin_accel_y_o = lay_q;
  assign lin_accel_z_o = laz_q;
  assign rate_x_o      = rx_q;
  assign rate_y_o      = ry_q;
  assign rate_z_o      = rz_q;
  assign g_force_o     = gf_q;

endmodule
`default_nettype wire

FILE: rtl/core/imugc_chk.sv
// Port-level assertions for the IMU gravity compensation core, with its bind.
`default_nettype none
module imugc_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        func_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [24:0] g_force_o
);

  // A result that is held back stays offered, with its g_force value unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(g_force_o))
    else $error("held result dropped or changed");

  // A measurement item keeps the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && func_i |=> in_stall_o)
    else $error("measurement item did not occupy the core");

  // A new result only appears at the end of busy work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while idle");

  // The core only becomes busy right after taking an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i))
    else $error("core became busy without an item");

endmodule

bind imu_gravity_compensation_core imugc_chk u_imugc_chk (.*);
`default_nettype wire

FILE: sim/imu_gravity_compensation_core_tb.sv
// Self-checking testbench for the IMU gravity and gyro bias compensation core.
`timescale 1ns / 100ps
`default_nettype none
module imu_gravity_compensation_core_tb;
  import imugc_pkg::*;

  // Function codes of an input item.
  localparam logic FUNC_CAL  = 1'b0;
  localparam logic FUNC_MEAS = 1'b1;
  // The cycle budget leaves a wide margin for the whole run.
  localparam longint CYCLE_LIMIT = 64'd40_000_000;

  typedef struct packed {
    logic signed [25:0] lx, ly, lz, gx, gy, gz;
    logic        [24:0] mag;
  } imu_result_t;

  // Tracks the bias state of the core and the queue of predicted results.
  class compensation_scoreboard;
    int         sums [6];
    int         count;
    longint     bias [6];
    imu_result_t pending [$];
    int         errors, results, cal_sets, meas_up, meas_down, cal_items;

    function new();
      foreach (sums[i]) begin
        sums[i] = 0;
        bias[i] = 0;
      end
      count = 0;
    endfunction

    static function longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
    endfunction

    // (a * b) >> 62, kept to 64 bits.
    static function logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
    endfunction

    static function int round_q15(longint v);
      logic [63:0] u;
      if (v < 0) v = 0;
      u = v;
      return int'((u + 64'h0000_4000_0000_0000) >> 47);
    endfunction

    // Sine and cosine magnitudes in Q15 of r/16 degrees, r within a quarter turn.
    static function void quarter_trig(int r, output int s, output int c);
      logic [63:0] x, x2, ts, tc;
      longint ss, cs;
      x  = 64'(r) * STEP_Q62;
      x2 = mul_q62(x, x);
      ts = x;
      tc = Q62_ONE;
      ss = x;
      cs = Q62_ONE;
      for (int k = 1; k <= 13; k++) begin
        ts = mul_q62(ts, x2) / 64'((2 * k) * (2 * k + 1));
        tc = mul_q62(tc, x2) / 64'((2 * k - 1) * (2 * k));
        if (k % 2 == 1) begin
          ss -= longint'(ts);
          cs -= longint'(tc);
        end else begin
          ss += longint'(ts);
          cs += longint'(tc);
        end
      end
      s = round_q15(ss);
      c = round_q15(cs);
    endfunction

    static function logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    // Called for every accepted input item.
    function void note_item(logic func, logic link, logic signed [15:0] raw [6],
                            logic signed [12:0] steer);
      longint      lin [7];
      longint      ang, ex, ey;
      int          a, q, r, s0, c0, sn, cs;
      imu_result_t res;
      if (func == FUNC_CAL) begin
        cal_items++;
        foreach (sums[i]) sums[i] += int'(raw[i]);
        count++;
        if (count >= CAL_SAMPLES) begin
          foreach (sums[i]) begin
            bias[i] = floor_div(longint'(sums[i]) * 256, CAL_SAMPLES);
            sums[i] = 0;
          end
          count = 0;
          cal_sets++;
        end
        return;
      end
      foreach (lin[i]) lin[i] = 0;
      if (link) begin
        meas_up++;
        ang = -longint'(steer);
        a   = int'(((ang % 5760) + 5760) % 5760);
        q   = a / 1440;
        r   = a % 1440;
        quarter_trig(r, s0, c0);
        case (q)
          0:       begin sn = s0;  cs = c0;  end
          1:       begin sn = c0;  cs = -s0; end
          2:       begin sn = -s0; cs = -c0; end
          default: begin sn = -c0; cs = s0;  end
        endcase
        ex = bias[0] * cs - bias[1] * sn;
        ey = bias[0] * sn + bias[1] * cs;
        lin[0] = floor_div(longint'(raw[0]) * 8388608 - ex + 16384, 32768);
        lin[1] = floor_div(longint'(raw[1]) * 8388608 - ey + 16384, 32768);
        for (int i = 2; i < 6; i++) lin[i] = longint'(raw[i]) * 256 - bias[i];
        lin[6] = longint'(floor_sqrt(64'(lin[0] * lin[0]) + 64'(lin[1] * lin[1])));
      end else begin
        meas_down++;
      end
      res.lx  = lin[0][25:0];
      res.ly  = lin[1][25:0];
      res.lz  = lin[2][25:0];
      res.gx  = lin[3][25:0];
      res.gy  = lin[4][25:0];
      res.gz  = lin[5][25:0];
      res.mag = lin[6][24:0];
      pending.push_back(res);
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want, results);
    endtask

    // Called for every accepted result.
    task check_result(imu_result_t got);
      imu_result_t want;
      if (pending.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      want = pending.pop_front();
      if (got.lx !== want.lx) report("lin_accel_x", got.lx, want.lx);
      if (got.ly !== want.ly) report("lin_accel_y", got.ly, want.ly);
      if (got.lz !== want.lz) report("lin_accel_z", got.lz, want.lz);
      if (got.gx !== want.gx) report("rate_x", got.gx, want.gx);
      if (got.gy !== want.gy) report("rate_y", got.gy, want.gy);
      if (got.gz !== want.gz) report("rate_z", got.gz, want.gz);
      if (got.mag !== want.mag) report("g_force", got.mag, want.mag);
      results++;
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = 1'b0;
  logic link_ok = 1'b0;
  logic signed [15:0] ax = '0, ay = '0, az = '0, gx = '0, gy = '0, gz = '0;
  logic signed [12:0] steer = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [25:0] lin_x, lin_y, lin_z, rate_x, rate_y, rate_z;
  logic        [24:0] g_force;

  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  longint cycles = 0;
  compensation_scoreboard sb = new();

  imu_gravity_compensation_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .func_i(func), .link_ok_i(link_ok),
    .raw_accel_x_i(ax), .raw_accel_y_i(ay), .raw_accel_z_i(az),
    .raw_gyro_x_i(gx), .raw_gyro_y_i(gy), .raw_gyro_z_i(gz),
    .steer_angle_i(steer),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .lin_accel_x_o(lin_x), .lin_accel_y_o(lin_y), .lin_accel_z_o(lin_z),
    .rate_x_o(rate_x), .rate_y_o(rate_y), .rate_z_o(rate_z),
    .g_force_o(g_force)
  );

  // 20 ns clock period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The run is cut off if it ever exceeds the cycle budget.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycles);
      $display("imu_gravity_compensation_core_tb: done, errors");
      $finish;
    end
  end

  // Receiver side: stall at random with the current idle percentage.
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Input monitor: every accepted item goes to the predictor. The values seen
  // here are those before the edge, as the block sees them.
  always @(posedge clk_i) begin
    logic signed [15:0] raw [6];
    if (rst_ni && in_valid && !in_stall) begin
      raw = '{ax, ay, az, gx, gy, gz};
      sb.note_item(func, link_ok, raw, steer);
    end
  end

  // Output monitor: every accepted result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      sb.check_result('{lin_x, lin_y, lin_z, rate_x, rate_y, rate_z, g_force});
    end
  end

  // Drives one item and holds it until the block takes it. Random idle cycles
  // before the item come from the sender's idle percentage.
  task automatic send_item(logic f, logic l, logic signed [15:0] r [6],
                           logic signed [12:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    func     <= f;
    link_ok  <= l;
    ax <= r[0];
    ay <= r[1];
    az <= r[2];
    gx <= r[3];
    gy <= r[4];
    gz <= r[5];
    steer <= s;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Random sample value, biased toward the extremes now and then.
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'($urandom_range(8191)) - 16'sd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly a legal steering angle, sometimes any 13-bit pattern.
  function automatic logic signed [12:0] pick_steer();
    if ($urandom_range(9) == 0) return 13'($urandom);
    return 13'($urandom_range(5760)) - 13'sd2880;
  endfunction

  // Pause the sender until the result queue has drained.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_items(int n);
    logic signed [15:0] r [6];
    for (int i = 0; i < n; i++) begin
      foreach (r[j]) r[j] = pick_sample();
      if ($urandom_range(99) < 65) begin
        send_item(FUNC_CAL, 1'($urandom), r, pick_steer());
      end else begin
        send_item(FUNC_MEAS, $urandom_range(99) < 80, r, pick_steer());
      end
    end
  endtask

  initial begin
    logic signed [15:0] r [6];
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Before any calibration the biases are zero, so the linear
    // and rate outputs are the raw samples scaled by 256.
    r = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000};
    send_item(FUNC_MEAS, 1'b1, r, 13'sd0);
    r = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF};
    send_item(FUNC_MEAS, 1'b1, r, 13'sd2880);
    // Link down gives an all-zero result.
    send_item(FUNC_MEAS, 1'b0, r, 13'sd100);
    // A short calibration burst (link flag ignored on calibration) followed by
    // measurements at the angle extremes, quadrant edges and out-of-range codes.
    r = '{16'sd1200, -16'sd900, 16'sd4096, 16'sd65, -16'sd131, 16'sd7};
    send_item(FUNC_CAL, 1'b0, r, 13'sd0);
    send_item(FUNC_CAL, 1'b1, r, 13'sd0);
    foreach (r[j]) r[j] = 16'sd0;
    send_item(FUNC_MEAS, 1'b1, r, -13'sd2880);
    send_item(FUNC_MEAS, 1'b1, r, 13'sd1440);
    send_item(FUNC_MEAS, 1'b1, r, -13'sd1440);
    send_item(FUNC_MEAS, 1'b1, r, 13'sh0FFF);
    send_item(FUNC_MEAS, 1'b1, r, 13'sh1000);
    send_item(FUNC_MEAS, 1'b0, r, 13'sh1000);
    drain();

    // Random part in three idling phases. The first full calibration set lands
    // inside the first phase, so later measurements see nonzero biases.
    send_idle_pct = 36;
    recv_idle_pct = 84;
    random_items(430);
    drain();
    send_idle_pct = 84;
    recv_idle_pct = 36;
    random_items(430);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_items(430);
    in_valid <= 1'b0;
    // Let the input monitor record the last item before watching the queue.
    @(posedge clk_i);

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("Covered %0d calibration items (%0d complete sets), %0d link-up and %0d link-down",
             sb.cal_items, sb.cal_sets, sb.meas_up, sb.meas_down);
    $display("measurements; %0d results checked, %0d mismatches.", sb.results, sb.errors);
    if (sb.errors == 0) begin
      $display("imu_gravity_compensation_core_tb: done, clean");
    end else begin
      $display("imu_gravity_compensation_core_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/core/imugc_pkg.sv
rtl/core/imu_gravity_compensation_core.sv
rtl/core/imugc_chk.sv
sim/imu_gravity_compensation_core_tb.sv
